// File: hdl/bresenham_line_pixel_generator_top_defines.svh
// Assertion macros used by the checker of the line engine.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define BLPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define BLPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/blpg_pkg.sv
package blpg_pkg;

  localparam int COORD_BITS = 16;
  localparam int PIX_W      = 16;
  localparam int COLOR_W    = 32;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 13;
  localparam int PITCH_W    = 17;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 4 * PIX_W + COLOR_W;
  localparam int OUT_DATA_W = 2 * PIX_W + COLOR_W + ADDR_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2,
    REG_FRAME_BASE    = 2'd3
  } reg_idx_t;

  // One pixel handed from the stepper to the address stage.
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [PITCH_W-1:0] pitch;
    logic [ADDR_W-1:0]  base;
  } screen_cfg_t;

endpackage

// File: hdl/blpg_fifo.sv
module blpg_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  blpg_pkg::pixel_t push_data,
  input  logic             pop,
  output blpg_pkg::pixel_t pop_data,
  output logic             empty,
  output logic             full
);

  blpg_pkg::pixel_t                 mem_r [blpg_pkg::FIFO_DEPTH];
  logic [blpg_pkg::FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [blpg_pkg::FIFO_AW:0]       count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (blpg_pkg::FIFO_AW+1)'(blpg_pkg::FIFO_DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// File: hdl/blpg_front.sv
module blpg_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  blpg_pkg::func_t                    func,
  input  logic [blpg_pkg::IN_DATA_W-1:0]     data,
  output logic                               push,
  output blpg_pkg::pixel_t                   push_data
);

  localparam int CB = blpg_pkg::COORD_BITS;

  blpg_pkg::coord_t              cx_r, cy_r, tx_r, ty_r;
  blpg_pkg::coord_t              cx_nxt, cy_nxt, tx_nxt, ty_nxt;
  logic [CB:0]                   dx_r, dy_r, dx_nxt, dy_nxt;
  logic                          left_r, up_r, left_nxt, up_nxt;
  logic signed [CB+1:0]          err_r, err_nxt;
  logic [blpg_pkg::COLOR_W-1:0]  color_r, color_nxt;
  logic                          active_r, active_nxt;

  logic signed [blpg_pkg::PIX_W-1:0] in_sx, in_sy, in_ex, in_ey;
  blpg_pkg::coord_t              sx, sy, ex, ey;
  logic signed [CB:0]            diff_x, diff_y;
  logic [CB:0]                   abs_x, abs_y;
  logic signed [CB+2:0]          e2, neg_dy, pos_dx;
  logic                          move_x, move_y, last;

  assign in_sx = data[blpg_pkg::PIX_W-1:0];
  assign in_sy = data[2*blpg_pkg::PIX_W-1:blpg_pkg::PIX_W];
  assign in_ex = data[3*blpg_pkg::PIX_W-1:2*blpg_pkg::PIX_W];
  assign in_ey = data[4*blpg_pkg::PIX_W-1:3*blpg_pkg::PIX_W];
  assign sx = CB'(in_sx);
  assign sy = CB'(in_sy);
  assign ex = CB'(in_ex);
  assign ey = CB'(in_ey);

  assign diff_x = (CB+1)'(ex) - (CB+1)'(sx);
  assign diff_y = (CB+1)'(ey) - (CB+1)'(sy);
  assign abs_x  = diff_x[CB] ? (CB+1)'(-diff_x) : (CB+1)'(diff_x);
  assign abs_y  = diff_y[CB] ? (CB+1)'(-diff_y) : (CB+1)'(diff_y);

  // Bresenham decision on the stored error term
  assign e2     = {err_r, 1'b0};
  assign neg_dy = -$signed({2'b00, dy_r});
  assign pos_dx = $signed({2'b00, dx_r});
  assign move_x = (e2 > neg_dy);
  assign move_y = (e2 < pos_dx);

  always_comb begin
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    tx_nxt    = tx_r;
    ty_nxt    = ty_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    left_nxt  = left_r;
    up_nxt    = up_r;
    err_nxt   = err_r;
    color_nxt = color_r;
    push      = 1'b0;
    if (accept) begin
      if (func == blpg_pkg::FUNC_START) begin
        cx_nxt    = sx;
        cy_nxt    = sy;
        tx_nxt    = ex;
        ty_nxt    = ey;
        dx_nxt    = abs_x;
        dy_nxt    = abs_y;
        left_nxt  = !(sx < ex);
        up_nxt    = !(sy < ey);
        err_nxt   = $signed({1'b0, abs_x}) - $signed({1'b0, abs_y});
        color_nxt = data[blpg_pkg::IN_DATA_W-1:4*blpg_pkg::PIX_W];
        push      = 1'b1;
      end else if (active_r) begin
        err_nxt = err_r - (move_x ? $signed({1'b0, dy_r}) : '0)
                        + (move_y ? $signed({1'b0, dx_r}) : '0);
        if (move_x) cx_nxt = left_r ? cx_r - CB'(1) : cx_r + CB'(1);
        if (move_y) cy_nxt = up_r   ? cy_r - CB'(1) : cy_r + CB'(1);
        push = 1'b1;
      end
    end
  end

  assign last       = (cx_nxt == tx_nxt) && (cy_nxt == ty_nxt);
  assign active_nxt = push ? !last : active_r;

  assign push_data.x     = cx_nxt;
  assign push_data.y     = cy_nxt;
  assign push_data.color = color_nxt;
  assign push_data.last  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      tx_r     <= '0;
      ty_r     <= '0;
      dx_r     <= '0;
      dy_r     <= '0;
      left_r   <= 1'b0;
      up_r     <= 1'b0;
      err_r    <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      tx_r     <= tx_nxt;
      ty_r     <= ty_nxt;
      dx_r     <= dx_nxt;
      dy_r     <= dy_nxt;
      left_r   <= left_nxt;
      up_r     <= up_nxt;
      err_r    <= err_nxt;
      color_r  <= color_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// File: hdl/blpg_back.sv
module blpg_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  blpg_pkg::screen_cfg_t           cfg,
  input  logic                            fifo_empty,
  input  blpg_pkg::pixel_t                fifo_data,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [blpg_pkg::OUT_DATA_W-1:0] out_data,
  output logic                            out_inside,
  output logic                            out_last
);

  localparam int CB    = blpg_pkg::COORD_BITS;
  localparam int CMP_W = ((CB > blpg_pkg::SIZE_W) ? CB : blpg_pkg::SIZE_W) + 1;
  localparam int AW    = blpg_pkg::ADDR_W;

  logic                  adv;
  logic signed [CMP_W-1:0] xs, ys, ws, hs;
  logic                  in_scr;
  logic [AW-1:0]         y_u, x_u;
  logic [AW+blpg_pkg::PITCH_W-1:0] prod;

  logic                  s1_valid_r;
  blpg_pkg::pixel_t      s1_pix_r;
  logic                  s1_inside_r;
  logic [AW-1:0]         s1_prod_r;
  logic [AW-1:0]         addr_nxt;

  logic                  out_valid_r;
  logic [blpg_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                  out_inside_r, out_last_r;

  // whole pipe moves together unless the output holds a stalled result
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !fifo_empty;

  assign xs = CMP_W'(fifo_data.x);
  assign ys = CMP_W'(fifo_data.y);
  assign ws = $signed(CMP_W'(cfg.width));
  assign hs = $signed(CMP_W'(cfg.height));
  assign in_scr = !fifo_data.x[CB-1] && !fifo_data.y[CB-1] && (xs < ws) && (ys < hs);

  assign y_u  = AW'(fifo_data.y);
  assign prod = y_u * cfg.pitch;

  assign x_u      = AW'(s1_pix_r.x);
  assign addr_nxt = s1_inside_r ? cfg.base + s1_prod_r + {x_u[AW-3:0], 2'b00} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= !fifo_empty;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pix_r     <= fifo_data;
      s1_inside_r  <= in_scr;
      s1_prod_r    <= prod[AW-1:0];
      out_data_r   <= {addr_nxt, s1_pix_r.color,
                       blpg_pkg::PIX_W'(s1_pix_r.y), blpg_pkg::PIX_W'(s1_pix_r.x)};
      out_inside_r <= s1_inside_r;
      out_last_r   <= s1_pix_r.last;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_inside = out_inside_r;
  assign out_last   = out_last_r;

endmodule

// File: hdl/bresenham_line_pixel_generator_top.sv
// Channel | Dir | Ports                              | Contents
// in      | in  | in_tvalid/tready/tdata/tuser       | tuser = func, tdata = endpoints, color
// out     | out | out_tvalid/tready/tdata/tuser/tlast| tuser = inside_screen, tlast = last
// cfg     | in  | cfg_we/cfg_addr/cfg_wdata          | screen size, row pitch, frame base
//
// One request per clock while the queue has room; each accepted advance is one Bresenham step.
// A pixel passes the stepper and queue, then the registered multiply and address add.
// Synchronous active-low reset clears the stepper, queue and pipe valids; config
// goes to 640x480, pitch 2560, base 0.
// A stalled output fills the four-entry queue; in_tready drops only when it is full.
module bresenham_line_pixel_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] start_x, [31:16] start_y, [47:32] end_x, [63:48] end_y, [95:64] line_color
  input  logic [blpg_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] func
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] pixel_x, [31:16] pixel_y, [63:32] pixel_color, [95:64] pixel_address
  output logic [blpg_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] inside_screen
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [blpg_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [blpg_pkg::CFG_W-1:0]      cfg_wdata
);

  blpg_pkg::screen_cfg_t cfg_r;
  blpg_pkg::pixel_t      push_data, pop_data;
  logic                  accept, push, pop, fifo_empty, fifo_full;

  // config registers; writes must arrive only while idle, which the block leaves to the user
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= blpg_pkg::SIZE_W'(640);
      cfg_r.height <= blpg_pkg::SIZE_W'(480);
      cfg_r.pitch  <= blpg_pkg::PITCH_W'(2560);
      cfg_r.base   <= '0;
    end else if (cfg_we) begin
      unique case (blpg_pkg::reg_idx_t'(cfg_addr))
        blpg_pkg::REG_SCREEN_WIDTH:  cfg_r.width  <= cfg_wdata[blpg_pkg::SIZE_W-1:0];
        blpg_pkg::REG_SCREEN_HEIGHT: cfg_r.height <= cfg_wdata[blpg_pkg::SIZE_W-1:0];
        blpg_pkg::REG_ROW_PITCH:     cfg_r.pitch  <= cfg_wdata[blpg_pkg::PITCH_W-1:0];
        blpg_pkg::REG_FRAME_BASE:    cfg_r.base   <= cfg_wdata[blpg_pkg::ADDR_W-1:0];
      endcase
    end
  end

  // front takes a request whenever the queue has room
  assign in_tready = !fifo_full;
  assign accept    = in_tvalid && in_tready;

  blpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (blpg_pkg::func_t'(in_tuser)),
    .data      (in_tdata),
    .push      (push),
    .push_data (push_data)
  );

  blpg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  // back does the clip test and frame buffer address
  blpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .fifo_data  (pop_data),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata),
    .out_inside (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

// File: hdl/blpg_checker.sv
`include "bresenham_line_pixel_generator_top_defines.svh"

module blpg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [blpg_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  localparam int PW = blpg_pkg::PIX_W;
  localparam int AL = 2 * PW + blpg_pkg::COLOR_W;

  `BLPG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled pixel changed")
  `BLPG_ASSERT_IMPL(a_addr_zero, out_tvalid && !out_tuser, out_tdata[blpg_pkg::OUT_DATA_W-1:AL] == '0, "clipped pixel has address")
  `BLPG_ASSERT_IMPL(a_inside_nonneg, out_tvalid && out_tuser, !out_tdata[PW-1] && !out_tdata[2*PW-1], "negative pixel flagged inside")

endmodule

bind bresenham_line_pixel_generator_top blpg_checker u_blpg_checker (.*);
